FILE: hdl/sim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sim_pkg
// Shared types and constants of the skeleton identity matcher.
// ----------------------------------------------------------------------------
package sim_pkg;

   localparam int unsigned NUM_SLOTS     = 6;
   localparam int unsigned NUM_BONES     = 5;
   localparam int unsigned SLOT_BITS     = 3;
   localparam int unsigned BONE_BITS     = 3;
   localparam int unsigned LABEL_BITS    = 4;
   localparam int unsigned MAX_LABELS    = 16;
   localparam int unsigned DIST_OUT_BITS = 37;

   localparam logic OP_TRAIN    = 1'b0;
   localparam logic OP_IDENTIFY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACC,
      ST_ROOT,
      ST_TRAIN,
      ST_SEARCH
   } state_type;

   // bone length stream handed from cell to cell
   typedef struct packed {
      logic                 vld;
      logic                 first;
      logic [BONE_BITS-1:0] idx;
   } strm_ctrl_type;

   // running best travelling down the chain
   typedef struct packed {
      logic                  found;
      logic [LABEL_BITS-1:0] label;
   } tok_ctrl_type;

   function automatic logic [SLOT_BITS-1:0] bone_a(input logic [BONE_BITS-1:0] idx);
      logic [SLOT_BITS-1:0] r;
      unique case (idx)
         3'd0:    r = 3'd0;
         3'd1:    r = 3'd1;
         default: r = 3'd2;
      endcase
      return r;
   endfunction

   function automatic logic [SLOT_BITS-1:0] bone_b(input logic [BONE_BITS-1:0] idx);
      logic [SLOT_BITS-1:0] r;
      unique case (idx)
         3'd0:    r = 3'd1;
         3'd1:    r = 3'd2;
         3'd2:    r = 3'd3;
         3'd3:    r = 3'd4;
         default: r = 3'd5;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/skeleton_identity_matcher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skeleton_identity_matcher_top
// Nearest pattern match of a skeleton by five bone lengths.
// ----------------------------------------------------------------------------
// Joints come in on the req_ channel, one beat each, and go to a six row
// joint buffer. A beat with req_last_joint starts the work: each of the
// five bones is read from the buffer, its squared length is accumulated
// over the three axes, and its square root is taken. A train then writes
// the cell of its label in the pattern chain, if the chain has one. An
// identify streams the bones through the chain of min(PATTERN_ENTRIES,16)
// cells, one cell per cycle, and then registers its beat for rsp_.
// req_ready is low while a skeleton is in work. The response waits in an
// output register while rsp_ready is low; new joints are still taken, and
// the next identify holds before its search until the register is free.
// Reset clears the joint buffer and all pattern valid bits.
// ----------------------------------------------------------------------------
module skeleton_identity_matcher_top
   import sim_pkg::*;
#(
   parameter int unsigned PATTERN_ENTRIES = 16,
   parameter int unsigned COORD_BITS      = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_operation,
   input  wire logic [LABEL_BITS-1:0]    req_label,
   input  wire logic [SLOT_BITS-1:0]     req_joint_slot,
   input  wire logic signed [15:0]       req_joint_x,
   input  wire logic signed [15:0]       req_joint_y,
   input  wire logic signed [15:0]       req_joint_z,
   input  wire logic                     req_last_joint,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_matched,
   output logic      [LABEL_BITS-1:0]    rsp_best_label,
   output logic      [DIST_OUT_BITS-1:0] rsp_best_distance
);

   // wider coordinates arrive as plain 16-bit values
   localparam int unsigned CW       = (COORD_BITS > 16) ? 17 : COORD_BITS;
   localparam int unsigned LW       = CW + 1;
   localparam int unsigned SW       = 2 * LW;
   localparam int unsigned DW       = 2 * LW + 3;
   localparam int unsigned NCELL    = (PATTERN_ENTRIES < MAX_LABELS) ?
                                      PATTERN_ENTRIES : MAX_LABELS;
   localparam int unsigned CNT_END  = NUM_BONES + NCELL;
   localparam int unsigned CNT_BITS = $clog2(CNT_END + 1);

   state_type            state_ff, state_in;
   logic [BONE_BITS-1:0] bone_ff, bone_in;
   logic [1:0]           axis_ff, axis_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]        sum_ff, sum_in;
   logic [LW-1:0]        cur_ff [NUM_BONES];
   logic                 op_ff;
   logic [LABEL_BITS-1:0] label_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff;
   logic [LABEL_BITS-1:0] rsp_label_ff;
   logic [DIST_OUT_BITS-1:0] rsp_dist_ff;

   logic                 accept;
   logic                 go;
   logic                 capture;
   logic                 root_start;
   logic                 root_done;
   logic [LW-1:0]        root_val;
   logic                 mem_clear;
   logic                 mem_wr;
   logic                 cell_wr;
   logic [CW-1:0]        cx, cy, cz;
   logic [3*CW-1:0]      row_a, row_b;
   logic signed [CW-1:0] ca, cb;
   logic signed [CW:0]   cdiff;
   logic [CW:0]          cmag;
   logic [2*CW-1:0]      csq;
   logic [DIST_OUT_BITS-1:0] dist_sat;
   logic [NUM_BONES*LW-1:0]  cur_flat;

   strm_ctrl_type        strm_c [NCELL+1];
   logic [LW-1:0]        strm_v [NCELL+1];
   tok_ctrl_type         tok_c  [NCELL+1];
   logic [DW-1:0]        tok_d  [NCELL+1];

   // zero extension (wide) or truncation (narrow) of the beat's coordinates
   generate
      if (COORD_BITS > 16) begin : g_wide
         assign cx = {1'b0, req_joint_x};
         assign cy = {1'b0, req_joint_y};
         assign cz = {1'b0, req_joint_z};
      end else begin : g_narrow
         assign cx = req_joint_x[CW-1:0];
         assign cy = req_joint_y[CW-1:0];
         assign cz = req_joint_z[CW-1:0];
      end
   endgenerate

   assign accept = req_valid && req_ready;
   assign mem_wr = accept && (req_joint_slot < SLOT_BITS'(NUM_SLOTS));

   sim_joint_mem #(
      .ROW_BITS (3 * CW)
   ) u_joints (
      .clock     (clock),
      .reset     (reset),
      .clear     (mem_clear),
      .wr_en     (mem_wr),
      .wr_addr   (req_joint_slot),
      .wr_data   ({cz, cy, cx}),
      .rd_a_addr (bone_a(bone_ff)),
      .rd_b_addr (bone_b(bone_ff)),
      .rd_a_data (row_a),
      .rd_b_data (row_b)
   );

   sim_isqrt #(
      .ROOT_BITS (LW)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sum_in),
      .root     (root_val),
      .done     (root_done)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_joint) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               if (bone_ff == BONE_BITS'(NUM_BONES - 1)) begin
                  state_in = (op_ff == OP_TRAIN) ? ST_TRAIN : ST_SEARCH;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_TRAIN: begin
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (cnt_ff == CNT_BITS'(CNT_END)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_ready  = 1'b0;
      root_start = 1'b0;
      mem_clear  = 1'b0;
      cell_wr    = 1'b0;
      go         = 1'b0;
      capture    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready  = 1'b1;
         ST_READ:   ;
         ST_ACC:    root_start = (axis_ff == 2'd2);
         ST_ROOT:   mem_clear  = root_done && (bone_ff == BONE_BITS'(NUM_BONES - 1));
         ST_TRAIN:  cell_wr    = ({1'b0, label_ff} < (LABEL_BITS + 1)'(NCELL));
         ST_SEARCH: begin
            // hold before the search while the last response is not taken
            go      = !((cnt_ff == '0) && rsp_valid_ff);
            capture = (cnt_ff == CNT_BITS'(CNT_END));
         end
         default: ;
      endcase
   end

   // squared distance of one bone, one axis a cycle
   always_comb begin
      unique case (axis_ff)
         2'd0:    begin ca = row_a[0 +: CW];    cb = row_b[0 +: CW];    end
         2'd1:    begin ca = row_a[CW +: CW];   cb = row_b[CW +: CW];   end
         default: begin ca = row_a[2*CW +: CW]; cb = row_b[2*CW +: CW]; end
      endcase
      cdiff = (CW + 1)'(ca) - (CW + 1)'(cb);
      cmag  = cdiff[CW] ? (CW + 1)'(-cdiff) : (CW + 1)'(cdiff);
      csq   = cmag[CW-1:0] * cmag[CW-1:0];
      sum_in = ((axis_ff == 2'd0) ? '0 : sum_ff) + SW'(csq);
   end

   always_comb begin
      bone_in = bone_ff;
      axis_in = axis_ff;
      cnt_in  = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            bone_in = '0;
            cnt_in  = '0;
         end
         ST_READ: axis_in = '0;
         ST_ACC:  axis_in = axis_ff + 2'd1;
         ST_ROOT: begin
            if (root_done) begin
               bone_in = bone_ff + BONE_BITS'(1);
            end
         end
         ST_TRAIN: ;
         ST_SEARCH: begin
            if (go) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         default: ;
      endcase
      rsp_valid_in = capture ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bone_ff <= bone_in;
      axis_ff <= axis_in;
      cnt_ff  <= cnt_in;
      if (state_ff == ST_ACC) begin
         sum_ff <= sum_in;
      end
      if (accept) begin
         op_ff    <= req_operation;
         label_ff <= req_label;
      end
      if (state_ff == ST_ROOT && root_done) begin
         cur_ff[bone_ff] <= root_val;
      end
      if (capture) begin
         rsp_matched_ff <= tok_c[NCELL].found;
         rsp_label_ff   <= tok_c[NCELL].label;
         rsp_dist_ff    <= dist_sat;
      end
   end

   generate
      if (DW > DIST_OUT_BITS) begin : g_sat
         assign dist_sat = (|tok_d[NCELL][DW-1:DIST_OUT_BITS]) ? '1 :
                           tok_d[NCELL][DIST_OUT_BITS-1:0];
      end else begin : g_nosat
         assign dist_sat = DIST_OUT_BITS'(tok_d[NCELL]);
      end
   endgenerate

   // bone stream and starting best into the head of the chain
   always_comb begin
      for (int i = 0; i < NUM_BONES; i++) begin
         cur_flat[i*LW +: LW] = cur_ff[i];
      end
      strm_c[0].vld   = (state_ff == ST_SEARCH) && go &&
                        (cnt_ff < CNT_BITS'(NUM_BONES));
      strm_c[0].first = (cnt_ff == '0);
      strm_c[0].idx   = cnt_ff[BONE_BITS-1:0];
      unique case (cnt_ff[BONE_BITS-1:0])
         3'd0:    strm_v[0] = cur_ff[0];
         3'd1:    strm_v[0] = cur_ff[1];
         3'd2:    strm_v[0] = cur_ff[2];
         3'd3:    strm_v[0] = cur_ff[3];
         3'd4:    strm_v[0] = cur_ff[4];
         default: strm_v[0] = '0;
      endcase
      tok_c[0].found = 1'b0;
      tok_c[0].label = '0;
      tok_d[0]       = '0;
   end

   generate
      for (genvar k = 0; k < NCELL; k++) begin : g_cell
         sim_cell #(
            .LEN_BITS  (LW),
            .DIST_BITS (DW),
            .LABEL     (k)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .wr_en        (cell_wr && (label_ff == LABEL_BITS'(k))),
            .wr_bones     (cur_flat),
            .strm_in      (strm_c[k]),
            .strm_val_in  (strm_v[k]),
            .strm_out     (strm_c[k+1]),
            .strm_val_out (strm_v[k+1]),
            .tok_in       (tok_c[k]),
            .tok_dist_in  (tok_d[k]),
            .tok_out      (tok_c[k+1]),
            .tok_dist_out (tok_d[k+1])
         );
      end
   endgenerate

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = rsp_matched_ff;
   assign rsp_best_label    = rsp_label_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule
`default_nettype wire

FILE: hdl/sim_joint_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sim_joint_mem
// Joint buffer: one row of three coordinates per slot, two registered read
// ports, row valid bits so a cleared row reads as zero.
// ----------------------------------------------------------------------------
module sim_joint_mem
   import sim_pkg::*;
#(
   parameter int unsigned ROW_BITS = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 clear,
   input  wire logic                 wr_en,
   input  wire logic [SLOT_BITS-1:0] wr_addr,
   input  wire logic [ROW_BITS-1:0]  wr_data,
   input  wire logic [SLOT_BITS-1:0] rd_a_addr,
   input  wire logic [SLOT_BITS-1:0] rd_b_addr,
   output logic      [ROW_BITS-1:0]  rd_a_data,
   output logic      [ROW_BITS-1:0]  rd_b_data
);

   logic [ROW_BITS-1:0]  rows_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] vld_ff;
   logic [NUM_SLOTS-1:0] vld_in;
   logic [ROW_BITS-1:0]  rd_a_ff;
   logic [ROW_BITS-1:0]  rd_b_ff;
   logic                 rd_a_vld_ff;
   logic                 rd_b_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (clear) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[wr_addr] <= wr_data;
      end
      rd_a_ff     <= rows_ff[rd_a_addr];
      rd_b_ff     <= rows_ff[rd_b_addr];
      rd_a_vld_ff <= vld_ff[rd_a_addr];
      rd_b_vld_ff <= vld_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_b_data = rd_b_vld_ff ? rd_b_ff : '0;

endmodule
`default_nettype wire

FILE: hdl/sim_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sim_isqrt
// Floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sim_isqrt
   import sim_pkg::*;
#(
   parameter int unsigned ROOT_BITS = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [2*ROOT_BITS-1:0] radicand,
   output logic      [ROOT_BITS-1:0]   root,
   output logic                        done
);

   localparam int unsigned CNT_BITS = $clog2(ROOT_BITS + 1);

   logic [2*ROOT_BITS-1:0] n_ff, n_in;
   logic [ROOT_BITS+1:0]   rem_ff, rem_in;
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [ROOT_BITS+3:0]   rem_sh;
   logic [ROOT_BITS+3:0]   trial;
   logic [ROOT_BITS+3:0]   diff;
   logic                   ge;

   always_comb begin
      rem_sh  = {rem_ff, n_ff[2*ROOT_BITS-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_sh - trial;
      ge      = rem_sh >= trial;
      n_in    = n_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in    = {n_ff[2*ROOT_BITS-3:0], 2'b00};
         rem_in  = ge ? diff[ROOT_BITS+1:0] : rem_sh[ROOT_BITS+1:0];
         root_in = {root_ff[ROOT_BITS-2:0], ge};
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

FILE: hdl/sim_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sim_cell
// One pattern entry: holds five bone lengths, sums its squared distance
// from the passing bone stream, and updates the passing best.
// ----------------------------------------------------------------------------
module sim_cell
   import sim_pkg::*;
#(
   parameter int unsigned LEN_BITS  = 17,
   parameter int unsigned DIST_BITS = 37,
   parameter int unsigned LABEL     = 0
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [NUM_BONES*LEN_BITS-1:0] wr_bones,
   input  wire strm_ctrl_type                 strm_in,
   input  wire logic [LEN_BITS-1:0]           strm_val_in,
   output strm_ctrl_type                      strm_out,
   output logic      [LEN_BITS-1:0]           strm_val_out,
   input  wire tok_ctrl_type                  tok_in,
   input  wire logic [DIST_BITS-1:0]          tok_dist_in,
   output tok_ctrl_type                       tok_out,
   output logic      [DIST_BITS-1:0]          tok_dist_out
);

   localparam logic [LABEL_BITS-1:0] CELL_LABEL = LABEL_BITS'(LABEL);

   logic [LEN_BITS-1:0]   pat_ff [NUM_BONES];
   logic                  valid_ff;
   logic [DIST_BITS-1:0]  acc_ff, acc_in;
   strm_ctrl_type         strm_ff;
   logic [LEN_BITS-1:0]   strm_val_ff;
   tok_ctrl_type          tok_ff, tok_in_sel;
   logic [DIST_BITS-1:0]  tok_dist_ff, tok_dist_sel;
   logic [LEN_BITS-1:0]   pat_sel;
   logic [LEN_BITS-1:0]   delta;
   logic [2*LEN_BITS-1:0] sq;
   logic                  better;

   always_comb begin
      unique case (strm_in.idx)
         3'd0:    pat_sel = pat_ff[0];
         3'd1:    pat_sel = pat_ff[1];
         3'd2:    pat_sel = pat_ff[2];
         3'd3:    pat_sel = pat_ff[3];
         3'd4:    pat_sel = pat_ff[4];
         default: pat_sel = '0;
      endcase
      delta  = (pat_sel > strm_val_in) ? pat_sel - strm_val_in : strm_val_in - pat_sel;
      sq     = delta * delta;
      acc_in = acc_ff;
      if (strm_in.vld) begin
         acc_in = (strm_in.first ? '0 : acc_ff) + DIST_BITS'(sq);
      end
      // strict less keeps the lower label on a tie
      better       = valid_ff && (!tok_in.found || (acc_ff < tok_dist_in));
      tok_in_sel   = tok_in;
      tok_dist_sel = tok_dist_in;
      if (better) begin
         tok_in_sel.found = 1'b1;
         tok_in_sel.label = CELL_LABEL;
         tok_dist_sel     = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         strm_ff.vld <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff <= 1'b1;
         end
         strm_ff.vld <= strm_in.vld;
      end
      if (wr_en) begin
         for (int i = 0; i < NUM_BONES; i++) begin
            pat_ff[i] <= wr_bones[i*LEN_BITS +: LEN_BITS];
         end
      end
      strm_ff.first <= strm_in.first;
      strm_ff.idx   <= strm_in.idx;
      strm_val_ff   <= strm_val_in;
      acc_ff        <= acc_in;
      tok_ff        <= tok_in_sel;
      tok_dist_ff   <= tok_dist_sel;
   end

   assign strm_out     = strm_ff;
   assign strm_val_out = strm_val_ff;
   assign tok_out      = tok_ff;
   assign tok_dist_out = tok_dist_ff;

endmodule
`default_nettype wire

FILE: sim/skeleton_identity_matcher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skeleton_identity_matcher_top_tb
// Checks bone length training and nearest pattern search against a predictor.
// ----------------------------------------------------------------------------
module skeleton_identity_matcher_top_tb;
   import sim_pkg::*;

   typedef struct {
      logic              operation;
      logic [3:0]        label;
      logic [2:0]        slot;
      logic signed [15:0] x, y, z;
      logic              last;
   } joint_beat_type;

   typedef struct {
      logic        matched;
      logic [3:0]  label;
      logic [36:0] distance;
   } match_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = 1'b0;
   logic [3:0] req_label = '0;
   logic [2:0] req_joint_slot = '0;
   logic signed [15:0] req_joint_x = '0, req_joint_y = '0, req_joint_z = '0;
   logic req_last_joint = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_matched;
   logic [3:0] rsp_best_label;
   logic [36:0] rsp_best_distance;

   skeleton_identity_matcher_top dut (.*);

   joint_beat_type pending_beats[$];
   match_type      expected_matches[$];
   int          error_count = 0;
   int          match_count = 0;
   int          skeleton_count = 0;
   bit          stimulus_done = 1'b0;

   // predictor state
   longint      joint_pos[6][3];
   longint      trained_len[16][5];
   bit          trained_ok[16];

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint isqrt_floor(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint bone_len(int a, int b);
      longint sum = 0;
      longint d;
      for (int k = 0; k < 3; k++) begin
         d = joint_pos[a][k] - joint_pos[b][k];
         sum += d * d;
      end
      return isqrt_floor(sum);
   endfunction

   task automatic predict_skeleton(joint_beat_type b);
      longint cur[5];
      longint sum_sq, best, d;
      bit found;
      int best_lab;
      match_type m;
      if (b.slot < NUM_SLOTS) begin
         joint_pos[b.slot][0] = b.x;
         joint_pos[b.slot][1] = b.y;
         joint_pos[b.slot][2] = b.z;
      end
      if (!b.last) return;
      cur[0] = bone_len(0, 1);
      cur[1] = bone_len(1, 2);
      cur[2] = bone_len(2, 3);
      cur[3] = bone_len(2, 4);
      cur[4] = bone_len(2, 5);
      foreach (joint_pos[i, k]) joint_pos[i][k] = 0;
      skeleton_count++;
      if (b.operation == OP_TRAIN) begin
         for (int i = 0; i < 5; i++) trained_len[b.label][i] = cur[i];
         trained_ok[b.label] = 1'b1;
         return;
      end
      found = 1'b0;
      best = 0;
      best_lab = 0;
      for (int e = 0; e < 16; e++) begin
         if (!trained_ok[e]) continue;
         sum_sq = 0;
         for (int i = 0; i < 5; i++) begin
            d = trained_len[e][i] - cur[i];
            sum_sq += d * d;
         end
         if (!found || sum_sq < best) begin
            found = 1'b1;
            best = sum_sq;
            best_lab = e;
         end
      end
      m.matched = found;
      m.label = best_lab[3:0];
      m.distance = best[36:0];
      expected_matches.insert(expected_matches.size(), m);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                         : $urandom_range(0, 2);
   endfunction

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 4000) - 2000);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic add_beat(logic op, logic [3:0] lab, logic [2:0] slot,
                           logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic last);
      joint_beat_type b;
      b.operation = op; b.label = lab; b.slot = slot;
      b.x = x; b.y = y; b.z = z; b.last = last;
      pending_beats.insert(pending_beats.size(), b);
   endtask

   // stimulus
   initial begin
      int n, slot;
      logic op;
      // identify with nothing trained, on an empty skeleton
      add_beat(OP_IDENTIFY, 4'd3, 3'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      // extremes across slots
      add_beat(OP_TRAIN, 4'd15, 3'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
      add_beat(OP_TRAIN, 4'd15, 3'd1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      add_beat(OP_TRAIN, 4'd15, 3'd3, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
      add_beat(OP_TRAIN, 4'd15, 3'd4, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
      add_beat(OP_TRAIN, 4'd15, 3'd5, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
      // slots six and seven ignored, last still acts
      add_beat(OP_TRAIN, 4'd0, 3'd6, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
      add_beat(OP_TRAIN, 4'd0, 3'd7, 16'sh1234, 16'sh4321, 16'sh7fff, 1'b1);
      // tie between labels 0 and 15 is not exact; identify zero skeleton
      add_beat(OP_IDENTIFY, 4'd9, 3'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      // train label 14 equal to label 0, then identify the label 15 pattern
      add_beat(OP_TRAIN, 4'd14, 3'd2, 16'sd0, 16'sd0, 16'sd0, 1'b1);
      add_beat(OP_IDENTIFY, 4'd0, 3'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
      add_beat(OP_IDENTIFY, 4'd0, 3'd1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      add_beat(OP_IDENTIFY, 4'd0, 3'd3, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
      add_beat(OP_IDENTIFY, 4'd0, 3'd4, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
      add_beat(OP_IDENTIFY, 4'd0, 3'd5, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
      // random skeletons, mostly runs of three to seven beats on slots in order
      n = 15;
      while (n < 1650) begin
         op = ($urandom_range(0, 2) == 0) ? OP_TRAIN : OP_IDENTIFY;
         if ($urandom_range(0, 7) == 0) begin
            add_beat(op, 4'($urandom()), 3'($urandom()), rand_coord(), rand_coord(),
                     rand_coord(), 1'($urandom_range(0, 1)));
            n++;
         end else begin
            slot = $urandom_range(3, 7);
            for (int i = 0; i < slot; i++) begin
               add_beat(op, 4'($urandom()),
                        3'(($urandom_range(0, 5) == 0) ? $urandom() : i % 6),
                        rand_coord(), rand_coord(), rand_coord(),
                        i == slot - 1);
               n++;
            end
         end
      end
   end

   // driver
   int  req_gap = 0;
   bit  beat_live = 1'b0;
   always @(posedge clock) begin
      joint_beat_type b;
      if (!reset) begin
         if (beat_live && req_valid && req_ready) begin
            beat_live = 1'b0;
            req_gap = gap_len();
         end
         if (!beat_live) begin
            if (req_gap > 0 || pending_beats.size() == 0) begin
               if (req_gap > 0) req_gap--;
               req_valid <= 1'b0;
               if (pending_beats.size() == 0) stimulus_done = 1'b1;
            end else begin
               b = pending_beats.pop_front();
               predict_skeleton(b);
               beat_live = 1'b1;
               req_valid <= 1'b1;
               req_operation <= b.operation;
               req_label <= b.label;
               req_joint_slot <= b.slot;
               req_joint_x <= b.x;
               req_joint_y <= b.y;
               req_joint_z <= b.z;
               req_last_joint <= b.last;
            end
         end
      end
   end

   // monitor with random back pressure
   int rsp_gap = 0;
   always @(posedge clock) begin
      match_type m;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            match_count++;
            if (expected_matches.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               m = expected_matches.pop_front();
               if (rsp_matched !== m.matched)
                  report_mismatch("matched", rsp_matched, m.matched);
               if (rsp_best_label !== m.label)
                  report_mismatch("best_label", rsp_best_label, m.label);
               if (rsp_best_distance !== m.distance)
                  report_mismatch("best_distance", rsp_best_distance, m.distance);
            end
            rsp_gap = gap_len();
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && !beat_live);
      wait (expected_matches.size() == 0);
      repeat (300) @(posedge clock);
      $display("%0d skeletons processed, %0d identify beats checked",
               skeleton_count, match_count);
      if (error_count == 0 && expected_matches.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
